// ===== sv/hjkd_pkg.sv =====
// ----------------------------------------------------------------------------
// hjkd_pkg
// Shared types and constants for the headset jack and key detector.
// ----------------------------------------------------------------------------
`default_nettype none

package hjkd_pkg;

    localparam int CNT_W  = 10;
    localparam int HOLD_W = 8;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        POLE_NONE  = 2'd0,
        POLE_THREE = 2'd1,
        POLE_FOUR  = 2'd2
    } pole_t;

    typedef enum logic [2:0] {
        REG_PRESS    = 3'd0,
        REG_RELEASE  = 3'd1,
        REG_CLASSIFY = 3'd2,
        REG_CEILING  = 3'd3,
        REG_SKIP     = 3'd4
    } reg_idx_t;

    localparam logic OP_SCAN  = 1'b0;
    localparam logic OP_JACK  = 1'b1;
    localparam logic EVT_KEY  = 1'b0;
    localparam logic EVT_JACK = 1'b1;

    localparam logic [CNT_W-1:0]  PRESS_RST    = CNT_W'(2);
    localparam logic [CNT_W-1:0]  RELEASE_RST  = CNT_W'(3);
    localparam logic [CNT_W-1:0]  CLASSIFY_RST = CNT_W'(30);
    localparam logic [CNT_W-1:0]  CEILING_RST  = CNT_W'(1000);
    localparam logic [HOLD_W-1:0] SKIP_RST     = HOLD_W'(100);

    typedef struct packed {
        logic [CNT_W-1:0]  press;
        logic [CNT_W-1:0]  release_cnt;
        logic [CNT_W-1:0]  classify;
        logic [CNT_W-1:0]  ceiling;
        logic [HOLD_W-1:0] skip;
    } cfg_t;

    typedef struct packed {
        logic op;
        logic key;
        logic jack;
        logic susp;
    } item_t;

    typedef struct packed {
        logic  vld;
        logic  kind;
        logic  down;
        pole_t jtype;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/headset_jack_key_detector.sv =====
// A word accepted is held in the input register; its result, if any, is
// written to the output register when that register is free to take it.
// Throughput: one word per cycle while the output is not stalled; the state
// update for a word is combinational between the input and result registers.
// Reset: rst_n clears all detector state, empties both registers and loads
// the threshold registers with their defaults.
// ----------------------------------------------------------------------------
// headset_jack_key_detector
// Headset jack type and key press detector with an APB threshold port.
// ----------------------------------------------------------------------------
`default_nettype none

module headset_jack_key_detector (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [hjkd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [hjkd_pkg::DATA_W-1:0] pwdata,
    output      logic [hjkd_pkg::DATA_W-1:0] prdata,
    output      logic                        pready,
    input  wire logic                        in_valid,
    output      logic                        in_stall,
    input  wire logic                        operation,
    input  wire logic                        key_pin,
    input  wire logic                        jack_pin,
    input  wire logic                        suspended,
    output      logic                        out_valid,
    input  wire logic                        out_stall,
    output      logic                        event_kind,
    output      logic                        key_down,
    output      logic [1:0]                  jack_type
);
    import hjkd_pkg::*;

    cfg_t  cfg;
    item_t item_reg;
    res_t  res;
    logic  in_vld_reg, in_vld_next;
    logic  out_vld_reg, out_vld_next;
    logic  kind_reg, down_reg;
    pole_t jtype_reg;
    logic  advance;
    logic  accept_in;

    hjkd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hjkd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign accept_in = in_valid && !in_stall;

    assign out_valid  = out_vld_reg;
    assign event_kind = kind_reg;
    assign key_down   = down_reg;
    assign jack_type  = jtype_reg;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept_in)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = res.vld;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            item_reg <= '{op: operation, key: key_pin, jack: jack_pin, susp: suspended};
        end
        if (advance && res.vld)
        begin
            kind_reg  <= res.kind;
            down_reg  <= res.down;
            jtype_reg <= res.jtype;
        end
    end

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_vld_reg && out_stall && in_vld_reg))
        else $error("input stalled without a held result");

    a_word_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> in_vld_reg)
        else $error("pending word dropped");

    a_key_report: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && kind_reg == EVT_KEY) |-> (jtype_reg == POLE_NONE))
        else $error("key report carries a jack type");

    a_jack_report: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && kind_reg == EVT_JACK) |-> !down_reg)
        else $error("jack report carries a key level");

endmodule

`default_nettype wire

// ===== sv/hjkd_cfg.sv =====
// ----------------------------------------------------------------------------
// hjkd_cfg
// APB register bank holding the detector thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module hjkd_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [hjkd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [hjkd_pkg::DATA_W-1:0] pwdata,
    output      logic [hjkd_pkg::DATA_W-1:0] prdata,
    output      logic                       pready,
    output      hjkd_pkg::cfg_t             cfg
);
    import hjkd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_PRESS:    cfg_next.press       = pwdata[CNT_W-1:0];
                REG_RELEASE:  cfg_next.release_cnt = pwdata[CNT_W-1:0];
                REG_CLASSIFY: cfg_next.classify    = pwdata[CNT_W-1:0];
                REG_CEILING:  cfg_next.ceiling     = pwdata[CNT_W-1:0];
                REG_SKIP:     cfg_next.skip        = pwdata[HOLD_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PRESS:    prdata = DATA_W'(cfg_reg.press);
            REG_RELEASE:  prdata = DATA_W'(cfg_reg.release_cnt);
            REG_CLASSIFY: prdata = DATA_W'(cfg_reg.classify);
            REG_CEILING:  prdata = DATA_W'(cfg_reg.ceiling);
            REG_SKIP:     prdata = DATA_W'(cfg_reg.skip);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press       <= PRESS_RST;
            cfg_reg.release_cnt <= RELEASE_RST;
            cfg_reg.classify    <= CLASSIFY_RST;
            cfg_reg.ceiling     <= CEILING_RST;
            cfg_reg.skip        <= SKIP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/hjkd_core.sv =====
// ----------------------------------------------------------------------------
// hjkd_core
// Detector state and the single-pass decision logic for one word.
// ----------------------------------------------------------------------------
`default_nettype none

module hjkd_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire hjkd_pkg::item_t item,
    input  wire hjkd_pkg::cfg_t  cfg,
    output      hjkd_pkg::res_t  res
);
    import hjkd_pkg::*;

    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              prev_reg, prev_next;
    logic              pressed_reg, pressed_next;
    logic              present_reg, present_next;
    pole_t             pole_reg, pole_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic [CNT_W-1:0]  cnt_scan;

    always_comb
    begin
        cnt_scan = '0;
        if (item.key == prev_reg)
        begin
            cnt_scan = (cnt_reg < cfg.ceiling) ? cnt_reg + CNT_W'(1) : cnt_reg;
        end
    end

    always_comb
    begin
        cnt_next     = cnt_reg;
        prev_next    = prev_reg;
        pressed_next = pressed_reg;
        present_next = present_reg;
        pole_next    = pole_reg;
        hold_next    = hold_reg;
        res          = '{vld: 1'b0, kind: EVT_KEY, down: 1'b0, jtype: POLE_NONE};

        if (item.op == OP_JACK)
        begin
            cnt_next = '0;
            if (item.jack)
            begin
                present_next = 1'b1;
            end
            else
            begin
                present_next = 1'b0;
                pole_next    = POLE_NONE;
                res          = '{vld: 1'b1, kind: EVT_JACK, down: 1'b0, jtype: POLE_NONE};
            end
        end
        else if (item.susp && (hold_reg < cfg.skip))
        begin
            hold_next = hold_reg + HOLD_W'(1);
        end
        else
        begin
            hold_next = '0;
            cnt_next  = cnt_scan;
            prev_next = item.key;
            if (item.key)
            begin
                priority if (cnt_scan == cfg.release_cnt && pressed_reg)
                begin
                    pressed_next = 1'b0;
                    res = '{vld: 1'b1, kind: EVT_KEY, down: 1'b0, jtype: POLE_NONE};
                end
                else if (cnt_scan == cfg.classify && present_reg)
                begin
                    pole_next = POLE_FOUR;
                    res = '{vld: 1'b1, kind: EVT_JACK, down: 1'b0, jtype: POLE_FOUR};
                end
                else
                begin
                    res.vld = 1'b0;
                end
            end
            else
            begin
                priority if (cnt_scan == cfg.press && pole_reg == POLE_FOUR && !pressed_reg)
                begin
                    pressed_next = 1'b1;
                    res = '{vld: 1'b1, kind: EVT_KEY, down: 1'b1, jtype: POLE_NONE};
                end
                else if (cnt_scan == cfg.classify && present_reg)
                begin
                    if (!pressed_reg)
                    begin
                        pole_next = POLE_THREE;
                        res = '{vld: 1'b1, kind: EVT_JACK, down: 1'b0, jtype: POLE_THREE};
                    end
                    else
                    begin
                        pressed_next = 1'b0;
                        res = '{vld: 1'b1, kind: EVT_KEY, down: 1'b0, jtype: POLE_NONE};
                    end
                end
                else
                begin
                    res.vld = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            prev_reg    <= 1'b0;
            pressed_reg <= 1'b0;
            present_reg <= 1'b0;
            pole_reg    <= POLE_NONE;
            hold_reg    <= '0;
        end
        else if (advance)
        begin
            cnt_reg     <= cnt_next;
            prev_reg    <= prev_next;
            pressed_reg <= pressed_next;
            present_reg <= present_next;
            pole_reg    <= pole_next;
            hold_reg    <= hold_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/hjkd_checker.sv =====
// ----------------------------------------------------------------------------
// hjkd_checker
// Watches the threshold port and both word channels of the jack and key
// detector, tracks the detector state for every accepted input word and
// compares each accepted output word with the oldest predicted event.
// ----------------------------------------------------------------------------
module hjkd_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [hjkd_pkg::ADDR_W-1:0] paddr,
    input  logic [hjkd_pkg::DATA_W-1:0] pwdata,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        operation,
    input  logic                        key_pin,
    input  logic                        jack_pin,
    input  logic                        suspended,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic                        event_kind,
    input  logic                        key_down,
    input  logic [1:0]                  jack_type,
    output int                          mismatches,
    output int                          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import hjkd_pkg::*;

    typedef struct packed {
        logic  kind;
        logic  down;
        pole_t jtype;
    } key_event_t;

    cfg_t              thr;
    logic [CNT_W-1:0]  stable_cnt;
    logic              prev_key;
    logic              pressed;
    logic              plugged;
    pole_t             pole;
    logic [HOLD_W-1:0] hold_cnt;
    key_event_t        events_q[$];
    int                err_cnt;

    function automatic bit detect_event(input logic op, input logic key, input logic jack,
                                        input logic susp, output key_event_t ev);
        ev = '{kind: EVT_KEY, down: 1'b0, jtype: POLE_NONE};
        if (op == OP_JACK)
        begin
            stable_cnt = '0;
            if (jack)
            begin
                plugged = 1'b1;
                return 1'b0;
            end
            plugged = 1'b0;
            pole = POLE_NONE;
            ev.kind = EVT_JACK;
            return 1'b1;
        end
        if (susp && hold_cnt < thr.skip)
        begin
            hold_cnt = hold_cnt + HOLD_W'(1);
            return 1'b0;
        end
        hold_cnt = '0;
        if (key == prev_key)
        begin
            if (stable_cnt < thr.ceiling)
                stable_cnt = stable_cnt + CNT_W'(1);
        end
        else
        begin
            stable_cnt = '0;
        end
        prev_key = key;
        if (key)
        begin
            if (stable_cnt == thr.release_cnt && pressed)
            begin
                pressed = 1'b0;
                return 1'b1;
            end
            if (stable_cnt == thr.classify && plugged)
            begin
                pole = POLE_FOUR;
                ev.kind = EVT_JACK;
                ev.jtype = POLE_FOUR;
                return 1'b1;
            end
            return 1'b0;
        end
        if (stable_cnt == thr.press && pole == POLE_FOUR && !pressed)
        begin
            pressed = 1'b1;
            ev.down = 1'b1;
            return 1'b1;
        end
        if (stable_cnt == thr.classify && plugged)
        begin
            if (!pressed)
            begin
                pole = POLE_THREE;
                ev.kind = EVT_JACK;
                ev.jtype = POLE_THREE;
                return 1'b1;
            end
            pressed = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        key_event_t ev;
        key_event_t want;
        if (!rst_n)
        begin
            thr = '{press: PRESS_RST, release_cnt: RELEASE_RST, classify: CLASSIFY_RST,
                    ceiling: CEILING_RST, skip: SKIP_RST};
            stable_cnt = '0;
            prev_key = 1'b0;
            pressed = 1'b0;
            plugged = 1'b0;
            pole = POLE_NONE;
            hold_cnt = '0;
            events_q.delete();
            err_cnt = 0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_PRESS:    thr.press = pwdata[CNT_W-1:0];
                    REG_RELEASE:  thr.release_cnt = pwdata[CNT_W-1:0];
                    REG_CLASSIFY: thr.classify = pwdata[CNT_W-1:0];
                    REG_CEILING:  thr.ceiling = pwdata[CNT_W-1:0];
                    REG_SKIP:     thr.skip = pwdata[HOLD_W-1:0];
                    default:      ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (events_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected word kind %0d down %0d type %0d",
                             $time, event_kind, key_down, jack_type);
                end
                else
                begin
                    want = events_q.pop_front();
                    if (event_kind !== want.kind)
                    begin
                        err_cnt++;
                        $display("%0t: event_kind expected %0d got %0d",
                                 $time, want.kind, event_kind);
                    end
                    if (key_down !== want.down)
                    begin
                        err_cnt++;
                        $display("%0t: key_down expected %0d got %0d",
                                 $time, want.down, key_down);
                    end
                    if (jack_type !== want.jtype)
                    begin
                        err_cnt++;
                        $display("%0t: jack_type expected %0d got %0d",
                                 $time, want.jtype, jack_type);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (detect_event(operation, key_pin, jack_pin, suspended, ev))
                    events_q.push_back(ev);
            end
            mismatches <= err_cnt;
            outstanding <= events_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the jack and key detector with directed and random scan and jack
// words across several threshold settings, with random idling and stalls on
// both channels, and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hjkd_pkg::*;

    localparam int LIMIT       = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_TAIL  = 4;
    localparam int PHASE_WORDS = 50;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic              operation;
    logic              key_pin;
    logic              jack_pin;
    logic              suspended;
    logic              out_valid;
    logic              out_stall;
    logic              event_kind;
    logic              key_down;
    logic [1:0]        jack_type;
    int                mismatches;
    int                outstanding;

    bit                tx_idle;
    bit                rx_quiet;
    bit                rx_hold_req;
    int                quiet_cycles;
    int                cur_classify;
    int                cur_skip;
    logic              run_level;
    int                run_left;
    int                susp_left;

    headset_jack_key_detector DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .key_pin    (key_pin),
        .jack_pin   (jack_pin),
        .suspended  (suspended),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_kind (event_kind),
        .key_down   (key_down),
        .jack_type  (jack_type)
    );

    hjkd_checker events_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .key_pin     (key_pin),
        .jack_pin    (jack_pin),
        .suspended   (suspended),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .key_down    (key_down),
        .jack_type   (jack_type),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic int pick_gap(input bit busy);
        int r;
        r = $urandom_range(0, 99);
        if (!busy || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random stalls, quiet stretches, and one long hold-off on request
    initial
    begin
        int len;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            else if (rx_quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                len = $urandom_range(0, 99);
                if (len < 60)
                begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
                else
                begin
                    out_stall <= 1'b1;
                    if (len < 95)
                        repeat ($urandom_range(1, 4)) @(posedge clk);
                    else
                        repeat ($urandom_range(20, 60)) @(posedge clk);
                end
            end
        end
    end

    task automatic send_word(input logic op, input logic key, input logic jack,
                             input logic susp);
        int gap;
        operation <= op;
        key_pin   <= key;
        jack_pin  <= jack;
        suspended <= susp;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        gap = pick_gap(tx_idle);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_scan(input logic key, input logic susp);
        send_word(OP_SCAN, key, 1'($urandom_range(0, 1)), susp);
    endtask

    task automatic send_jack(input logic jack);
        send_word(OP_JACK, 1'($urandom_range(0, 1)), jack, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_random();
        logic susp;
        if ($urandom_range(0, 99) < 5)
        begin
            send_jack($urandom_range(0, 9) < 7);
        end
        else
        begin
            if (run_left == 0)
            begin
                run_level = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 99) < 85)
                    run_left = $urandom_range(1, cur_classify + 4);
                else
                    run_left = $urandom_range(1, 45);
            end
            run_left--;
            if (susp_left == 0 && $urandom_range(0, 99) < 3)
                susp_left = $urandom_range(1, cur_skip + 2);
            susp = (susp_left != 0) || ($urandom_range(0, 99) < 2);
            if (susp_left != 0)
                susp_left--;
            send_scan(run_level, susp);
        end
    endtask

    task automatic reg_write(input reg_idx_t idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 4);
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic set_thresholds(input int press, input int rel, input int classify,
                                  input int ceiling, input int skip);
        reg_write(REG_PRESS, press);
        reg_write(REG_RELEASE, rel);
        reg_write(REG_CLASSIFY, classify);
        reg_write(REG_CEILING, ceiling);
        reg_write(REG_SKIP, skip);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        cur_classify = classify;
        cur_skip     = skip;
    endtask

    // hold the sender until every predicted word has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    initial
    begin
        int ph;
        int n;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        operation    = OP_SCAN;
        key_pin      = 1'b0;
        jack_pin     = 1'b0;
        suspended    = 1'b0;
        tx_idle      = 1'b0;
        rx_quiet     = 1'b1;
        rx_hold_req  = 1'b0;
        quiet_cycles = 0;
        run_level    = 1'b0;
        run_left     = 0;
        susp_left    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: four-pole detect, press, release, auto-release, suspend, removal
        set_thresholds(2, 3, 5, 8, 3);
        send_jack(1'b1);
        repeat (6) send_scan(1'b1, 1'b0);
        repeat (3) send_scan(1'b0, 1'b0);
        repeat (4) send_scan(1'b1, 1'b0);
        repeat (3) send_scan(1'b0, 1'b0);
        repeat (3) send_scan(1'b0, 1'b0);
        repeat (4) send_scan(1'b0, 1'b1);
        send_jack(1'b0);
        drain();

        for (ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: set_thresholds(1, 1, 1, 1, 0);
                1: set_thresholds($urandom_range(0, 2), $urandom_range(0, 2),
                                  $urandom_range(0, 2), $urandom_range(1, 3), 0);
                default:
                    set_thresholds($urandom_range(1, 10), $urandom_range(1, 10),
                                   $urandom_range(1, 16),
                                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                                               : $urandom_range(10, 40),
                                   $urandom_range(0, 8));
            endcase
            tx_idle  = ($urandom_range(0, 3) != 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if (ph == 2)
            begin
                tx_idle     = 1'b0;
                rx_quiet    = 1'b0;
                rx_hold_req = 1'b1;
            end
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                if (ph == 3 && n == PHASE_WORDS / 2)
                    drain();
                send_random();
            end
            drain();
        end

        // widest thresholds: long stable run into saturation, then a full suspend hold
        set_thresholds(1023, 1023, 1023, 1023, 255);
        tx_idle  = 1'b1;
        rx_quiet = 1'b0;
        send_jack(1'b1);
        repeat (1026) send_scan(1'b0, 1'b0);
        repeat (257) send_scan(1'b0, 1'b1);
        drain();

        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
